[hw/rtl/sjf_pkg.sv]
// Shared constants, types and character tables for the SSE JSON string framer.
// No dependencies; used by sjf_escape, sse_json_string_framer and sjf_checker.
`default_nettype none

package sjf_pkg;

    localparam int ESCAPE_BUFFER_BYTES = 4096;
    localparam int BUDGET_W            = $clog2(ESCAPE_BUFFER_BYTES);
    localparam int ESC_RESERVE         = 6;
    localparam int PREFIX_LEN          = 18;
    localparam int IDX_W               = $clog2(PREFIX_LEN);
    localparam int SUFFIX_LEN          = 4;
    localparam int CTRL_LIMIT          = 32;
    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    localparam logic [BUDGET_W-1:0] BUDGET_FULL = BUDGET_W'(ESCAPE_BUFFER_BYTES - 1);

    // output bytes spent per content byte
    localparam logic [2:0] COST_PLAIN   = 3'd1;
    localparam logic [2:0] COST_SHORT   = 3'd2;
    localparam logic [2:0] COST_UNICODE = 3'd6;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef struct packed {
        logic [7:0] data;
        logic       item_last;   // final byte of this request
        logic       prefix_done; // final byte of the frame prefix
        logic [2:0] cost;        // budget spent, valid with item_last
    } sjf_emit_t;

    // data: {"content":"
    function automatic logic [7:0] prefix_char(input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h64;
            5'd1:    ch = 8'h61;
            5'd2:    ch = 8'h74;
            5'd3:    ch = 8'h61;
            5'd4:    ch = 8'h3A;
            5'd5:    ch = 8'h20;
            5'd6:    ch = 8'h7B;
            5'd7:    ch = CH_QUOTE;
            5'd8:    ch = 8'h63;
            5'd9:    ch = 8'h6F;
            5'd10:   ch = 8'h6E;
            5'd11:   ch = 8'h74;
            5'd12:   ch = 8'h65;
            5'd13:   ch = 8'h6E;
            5'd14:   ch = 8'h74;
            5'd15:   ch = CH_QUOTE;
            5'd16:   ch = 8'h3A;
            5'd17:   ch = CH_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "}\n\n
    function automatic logic [7:0] suffix_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_QUOTE;
            2'd1:    ch = CH_RBRC;
            default: ch = CH_LF;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = CH_ZERO + {4'd0, nib};
        else
            ch = 8'h57 + {4'd0, nib}; // 'a' - 10
        return ch;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sjf_escape.sv]
// Byte selector: picks the frame byte for the current position of a request.
// Depends on sjf_pkg.
`default_nettype none

module sjf_escape (
    input  wire logic                       prefix_phase,
    input  wire logic                       action,
    input  wire logic [7:0]                 content_byte,
    input  wire logic [sjf_pkg::IDX_W-1:0]  idx,
    output sjf_pkg::sjf_emit_t              emit
);

    logic [7:0] short_char;
    logic       is_short;
    logic       is_ctrl;

    always_comb
    begin
        is_short   = 1'b1;
        short_char = content_byte;
        case (content_byte)
            sjf_pkg::CH_QUOTE: short_char = sjf_pkg::CH_QUOTE;
            sjf_pkg::CH_BSL:   short_char = sjf_pkg::CH_BSL;
            sjf_pkg::CH_LF:    short_char = sjf_pkg::CH_N;
            sjf_pkg::CH_CR:    short_char = sjf_pkg::CH_R;
            sjf_pkg::CH_TAB:   short_char = sjf_pkg::CH_T;
            default:           is_short   = 1'b0;
        endcase
    end

    assign is_ctrl = (content_byte < 8'(sjf_pkg::CTRL_LIMIT));

    always_comb
    begin
        emit.data        = 8'h00;
        emit.item_last   = 1'b0;
        emit.prefix_done = 1'b0;
        emit.cost        = sjf_pkg::COST_PLAIN;
        if (prefix_phase)
        begin
            emit.data        = sjf_pkg::prefix_char(idx);
            emit.prefix_done = (idx == sjf_pkg::IDX_W'(sjf_pkg::PREFIX_LEN - 1));
        end
        else if (action == sjf_pkg::ACT_END)
        begin
            emit.data      = sjf_pkg::suffix_char(idx[1:0]);
            emit.item_last = (idx == sjf_pkg::IDX_W'(sjf_pkg::SUFFIX_LEN - 1));
        end
        else if (is_short)
        begin
            emit.cost      = sjf_pkg::COST_SHORT;
            emit.data      = (idx == '0) ? sjf_pkg::CH_BSL : short_char;
            emit.item_last = (idx == sjf_pkg::IDX_W'(sjf_pkg::COST_SHORT - 3'd1));
        end
        else if (is_ctrl)
        begin
            // \u00XX
            emit.cost      = sjf_pkg::COST_UNICODE;
            emit.item_last = (idx == sjf_pkg::IDX_W'(sjf_pkg::COST_UNICODE - 3'd1));
            case (idx[2:0])
                3'd0:    emit.data = sjf_pkg::CH_BSL;
                3'd1:    emit.data = sjf_pkg::CH_U;
                3'd2:    emit.data = sjf_pkg::CH_ZERO;
                3'd3:    emit.data = sjf_pkg::CH_ZERO;
                3'd4:    emit.data = sjf_pkg::hex_char(content_byte[7:4]);
                default: emit.data = sjf_pkg::hex_char(content_byte[3:0]);
            endcase
        end
        else
        begin
            emit.data      = content_byte;
            emit.item_last = 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sse_json_string_framer.sv]
// SSE JSON string framer: wraps message bytes as  data: {"content":"..."}\n\n
// Depends on sjf_pkg and sjf_escape.
//
// Usage:
//   Request channel (req_valid / req_stall): action 0 carries one content byte,
//   action 1 closes the message. Result channel (res_valid / res_stall) gives
//   one frame byte per transfer; run_last marks the last byte of a request,
//   frame_end the closing newline, with frame_length and too_long. The user must
//   write capacity via cfg_write_en / cfg_write_data while idle; not enforced.
// Timing:
//   A request sits in one input register; unless res_stall holds the output
//   register, the selector produces one byte per cycle into it, which sets the
//   rate. An accepted request is registered in the input register, then its
//   first byte in the output register. A plain byte gives 1 output byte, a
//   short escape 2, a \u00XX escape 6, a close 4; a frame's first request adds
//   18 prefix bytes. Bytes beyond the escape budget are dropped with no result.
// Reset: no frame open, budget full, capacity 4096, both registers empty.
// Stall: res_stall holds the output register; the input register then holds
//   its request and req_stall rises until the byte stream moves on.
`default_nettype none

module sse_json_string_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        action,
    input  wire logic [7:0]  content_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             frame_end,
    output logic             too_long,
    output logic [15:0]      frame_length
);

    logic                          item_valid_reg, item_valid_next;
    logic                          item_action_reg;
    logic [7:0]                    item_byte_reg;
    logic [sjf_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          in_frame_reg, in_frame_next;
    logic [sjf_pkg::BUDGET_W-1:0]  budget_reg, budget_next;
    logic [15:0]                   count_reg, count_next;
    logic [15:0]                   capacity_reg;
    logic                          out_valid_reg, out_valid_next;

    sjf_pkg::sjf_emit_t emit;
    logic        drop;
    logic        emit_en;
    logic        item_done;
    logic        accept;
    logic        closing;
    logic [15:0] count_inc;

    sjf_escape u_escape (
        .prefix_phase (!in_frame_reg),
        .action       (item_action_reg),
        .content_byte (item_byte_reg),
        .idx          (idx_reg),
        .emit         (emit)
    );

    // budget spent: byte discarded without output
    assign drop      = item_valid_reg && (item_action_reg == sjf_pkg::ACT_BYTE) && in_frame_reg
                       && (budget_reg <= sjf_pkg::BUDGET_W'(sjf_pkg::ESC_RESERVE));
    assign emit_en   = item_valid_reg && !drop && (!out_valid_reg || !res_stall);
    assign item_done = drop || (emit_en && emit.item_last);
    assign req_stall = item_valid_reg && !item_done;
    assign accept    = req_valid && !req_stall;
    assign closing   = emit_en && emit.item_last && (item_action_reg == sjf_pkg::ACT_END);
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        in_frame_next   = in_frame_reg;
        budget_next     = budget_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;

        if (accept)
            item_valid_next = 1'b1;
        else if (item_done)
            item_valid_next = 1'b0;

        if (emit_en)
        begin
            out_valid_next = 1'b1;
            count_next     = count_inc;
            if (emit.item_last || emit.prefix_done)
                idx_next = '0;
            else
                idx_next = idx_reg + sjf_pkg::IDX_W'(1);
            if (emit.prefix_done)
                in_frame_next = 1'b1;
            if (emit.item_last)
                budget_next = budget_reg - sjf_pkg::BUDGET_W'(emit.cost);
            if (closing)
            begin
                in_frame_next = 1'b0;
                budget_next   = sjf_pkg::BUDGET_FULL;
                count_next    = '0;
            end
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            in_frame_reg   <= 1'b0;
            budget_reg     <= sjf_pkg::BUDGET_FULL;
            count_reg      <= '0;
            capacity_reg   <= sjf_pkg::CAPACITY_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            in_frame_reg   <= in_frame_next;
            budget_reg     <= budget_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
                capacity_reg <= cfg_write_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_action_reg <= action;
            item_byte_reg   <= content_byte;
        end
        if (emit_en)
        begin
            out_byte     <= emit.data;
            run_last     <= emit.item_last;
            frame_end    <= closing;
            too_long     <= closing && (count_inc >= capacity_reg);
            frame_length <= closing ? count_inc : 16'd0;
        end
    end

    assign res_valid = out_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/sjf_checker.sv]
// Port-level checks for sse_json_string_framer, attached by bind.
// Depends on sjf_pkg.
`default_nettype none

module sjf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        run_last,
    input wire logic        frame_end,
    input wire logic        too_long,
    input wire logic [15:0] frame_length
);

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && frame_end) |-> (run_last && out_byte == sjf_pkg::CH_LF))
        else $error("frame end not on final newline of a request");

    a_flag_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && too_long) |-> frame_end)
        else $error("too_long outside frame end");

    a_length_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !frame_end) |-> (frame_length == 16'd0))
        else $error("frame_length set outside frame end");

    a_close_follows_brace: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && out_byte == sjf_pkg::CH_RBRC && !run_last)
        |=> (!res_valid || (out_byte == sjf_pkg::CH_LF && !run_last)))
        else $error("closing brace not followed by newline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(out_byte) && $stable(run_last)))
        else $error("stalled result changed");

endmodule

bind sse_json_string_framer sjf_checker u_sjf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_end    (frame_end),
    .too_long     (too_long),
    .frame_length (frame_length)
);

`default_nettype wire
